>>> hdl/bpb_pkg.sv
package bpb_pkg;

    // request kinds
    localparam logic [1:0] FUNC_BRANCH   = 2'd0;
    localparam logic [1:0] FUNC_DIRECT   = 2'd1;
    localparam logic [1:0] FUNC_INDIRECT = 2'd2;

    // direction predictor modes
    localparam logic [2:0] MODE_STATIC_NT = 3'd0;
    localparam logic [2:0] MODE_STATIC_T  = 3'd1;
    localparam logic [2:0] MODE_ONE_BIT   = 3'd2;
    localparam logic [2:0] MODE_TWO_BIT   = 3'd3;
    localparam logic [2:0] MODE_GSHARE    = 3'd4;

    // configuration register indexes
    localparam logic [7:0] REG_MODE    = 8'd0;
    localparam logic [7:0] REG_PENALTY = 8'd1;
    localparam logic [7:0] REG_HIST    = 8'd2;
    localparam logic [7:0] REG_BTB_EN  = 8'd3;

    localparam logic [2:0] RST_MODE    = MODE_TWO_BIT;
    localparam logic [7:0] RST_PENALTY = 8'd3;
    localparam logic [4:0] RST_HIST    = 5'd8;
    localparam logic       RST_BTB_EN  = 1'b1;

    localparam int         HIST_W      = 16;
    localparam logic [1:0] CTR_INIT    = 2'd1;
    localparam logic [1:0] CTR_MAX     = 2'd3;
    localparam logic [7:0] DIRECT_COST = 8'd1;

    typedef struct packed {
        logic        valid;
        logic [63:0] tag;
        logic [63:0] target;
    } btb_entry_t;

    // saturating 2-bit counter step
    function automatic logic [1:0] ctr_update(input logic [1:0] ctr, input logic taken);
        logic [1:0] res;
        res = ctr;
        if (taken) begin
            if (ctr != CTR_MAX) res = ctr + 2'd1;
        end
        else begin
            if (ctr != 2'd0) res = ctr - 2'd1;
        end
        return res;
    endfunction

endpackage

>>> hdl/bpb_pht.sv
module bpb_pht #(
    parameter int ENTRIES = 256,
    parameter int IW      = 8
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_addr,
    output logic [1:0]    rd_data,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  logic [1:0]    wr_data
);
    logic [1:0] mem [ENTRIES];
    logic [1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

>>> hdl/bpb_btb.sv
module bpb_btb #(
    parameter int ENTRIES = 64,
    parameter int IW      = 6
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [IW-1:0]       rd_addr,
    output bpb_pkg::btb_entry_t rd_data,
    input  logic                wr_en,
    input  logic [IW-1:0]       wr_addr,
    input  bpb_pkg::btb_entry_t wr_data
);
    import bpb_pkg::*;

    btb_entry_t mem [ENTRIES];
    btb_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

>>> hdl/branch_predictor_with_btb_top.sv
// Flow: a request's tables are read at the accepting edge as it enters s1; it is
//   evaluated and written back as it leaves s1, which loads the result register.
// One request at a time: the counter table and BTB are
//   read and written back before the next request may read them.
// Reset (rst_n low, async): control and config registers take defaults, then
//   a clearing pass over max(COUNTER_ENTRIES, BTB_SLOTS) entries runs with in_stall high.
module branch_predictor_with_btb_top #(
    parameter int BTB_SLOTS       = 64,   // power of two, 1..4096
    parameter int COUNTER_ENTRIES = 256   // power of two, 16..4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [63:0] pc,
    input  logic [63:0] dest_pc,
    input  logic        taken,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  bubbles,
    output logic        mispredicted,
    output logic        pred_taken
);
    import bpb_pkg::*;

    localparam int PHT_IW    = $clog2(COUNTER_ENTRIES);
    localparam int BTB_IW    = (BTB_SLOTS > 1) ? $clog2(BTB_SLOTS) : 1;
    localparam int CLR_DEPTH = (COUNTER_ENTRIES > BTB_SLOTS) ? COUNTER_ENTRIES : BTB_SLOTS;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    localparam logic [BTB_IW-1:0] BTB_MASK = BTB_IW'(BTB_SLOTS - 1);
    localparam logic [CLR_W-1:0]  CLR_LAST = CLR_W'(CLR_DEPTH - 1);
    localparam logic [CLR_W:0]    CLR_PHT  = (CLR_W + 1)'(COUNTER_ENTRIES);
    localparam logic [CLR_W:0]    CLR_BTB  = (CLR_W + 1)'(BTB_SLOTS);

    // configuration
    logic [2:0] mode_reg;
    logic [7:0] penalty_reg;
    logic [4:0] hist_bits_reg;
    logic       btb_en_reg;

    // clearing pass after reset
    logic             clear_reg;
    logic [CLR_W-1:0] clr_cnt_reg;

    // global history
    logic [HIST_W-1:0] hist_reg;
    logic [HIST_W-1:0] hist_next;

    // evaluate stage: the request whose memory reads are in flight
    logic              s1_valid_reg;
    logic [1:0]        s1_func_reg;
    logic [63:0]       s1_pc_reg;
    logic [63:0]       s1_tgt_reg;
    logic              s1_taken_reg;
    logic [PHT_IW-1:0] s1_idx_reg;
    logic [BTB_IW-1:0] s1_slot_reg;

    // result register
    logic       out_valid_reg;
    logic [7:0] bubbles_reg;
    logic       mispred_reg;
    logic       pred_reg;

    logic              in_accept;
    logic              out_accept;
    logic              s1_done;
    logic [PHT_IW-1:0] pht_rd_addr;
    logic [BTB_IW-1:0] btb_rd_addr;
    logic [1:0]        ctr;
    btb_entry_t        btb_rd;

    logic              pht_we;
    logic [PHT_IW-1:0] pht_wa;
    logic [1:0]        pht_wd;
    logic              btb_we;
    logic [BTB_IW-1:0] btb_wa;
    btb_entry_t        btb_wd;

    logic              is_cond;
    logic              table_mode;
    logic              pred;
    logic              btb_hit;
    logic [7:0]        bub;
    logic [4:0]        hb_clip;
    logic [HIST_W-1:0] hist_mask;

    // Stall while clearing, while a request is being evaluated (the tables
    // and history must be written back before the next read), or when the
    // result register is full and not draining.
    assign in_stall   = clear_reg || s1_valid_reg || (out_valid_reg && out_stall);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign s1_done    = s1_valid_reg && (!out_valid_reg || !out_stall);

    // read addresses, taken from the request pc (counter index XORed with history in gshare mode)
    assign pht_rd_addr = (mode_reg == MODE_GSHARE)
                       ? (pc[PHT_IW:1] ^ hist_reg[PHT_IW-1:0])
                       : pc[PHT_IW:1];
    assign btb_rd_addr = pc[BTB_IW:1] & BTB_MASK;

    // evaluate
    assign is_cond    = (s1_func_reg == FUNC_BRANCH);
    assign table_mode = (mode_reg == MODE_ONE_BIT) || (mode_reg == MODE_TWO_BIT)
                     || (mode_reg == MODE_GSHARE);
    assign btb_hit    = btb_en_reg && btb_rd.valid && (btb_rd.tag == s1_pc_reg)
                     && (btb_rd.target == s1_tgt_reg);

    always_comb
    begin
        case (mode_reg)
            MODE_STATIC_T: pred = 1'b1;
            MODE_ONE_BIT:  pred = (ctr != 2'd0);
            MODE_TWO_BIT:  pred = ctr[1];
            MODE_GSHARE:   pred = ctr[1];
            default:       pred = 1'b0;
        endcase
    end

    always_comb
    begin
        bub = 8'd0;
        if (is_cond)
        begin
            if (pred != s1_taken_reg)
                bub = penalty_reg;
            else if (pred && !btb_hit)
                bub = penalty_reg;
        end
        else if (!btb_hit)
        begin
            bub = (s1_func_reg == FUNC_DIRECT) ? DIRECT_COST : penalty_reg;
        end
    end

    // history: shift in outcome, keep at most 16 bits
    assign hb_clip   = (hist_bits_reg > 5'd16) ? 5'd16 : hist_bits_reg;
    assign hist_mask = ~({HIST_W{1'b1}} << hb_clip);
    assign hist_next = {hist_reg[HIST_W-2:0], s1_taken_reg} & hist_mask;

    // write ports: clearing pass, else write-back of the finishing request
    always_comb
    begin
        pht_we = 1'b0;
        pht_wa = s1_idx_reg;
        pht_wd = ctr;
        btb_we = 1'b0;
        btb_wa = s1_slot_reg;
        btb_wd = '{valid: 1'b1, tag: s1_pc_reg, target: s1_tgt_reg};
        if (clear_reg)
        begin
            pht_we = ({1'b0, clr_cnt_reg} < CLR_PHT);
            pht_wa = clr_cnt_reg[PHT_IW-1:0];
            pht_wd = CTR_INIT;
            btb_we = ({1'b0, clr_cnt_reg} < CLR_BTB);
            btb_wa = clr_cnt_reg[BTB_IW-1:0] & BTB_MASK;
            btb_wd = '{valid: 1'b0, tag: 64'd0, target: 64'd0};
        end
        else if (s1_done)
        begin
            pht_we = is_cond && table_mode;
            pht_wd = (mode_reg == MODE_ONE_BIT) ? {1'b0, s1_taken_reg}
                                                : ctr_update(ctr, s1_taken_reg);
            btb_we = btb_en_reg && (is_cond ? s1_taken_reg : !btb_hit);
        end
    end

    bpb_pht #(
        .ENTRIES (COUNTER_ENTRIES),
        .IW      (PHT_IW)
    ) u_pht (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (pht_rd_addr),
        .rd_data (ctr),
        .wr_en   (pht_we),
        .wr_addr (pht_wa),
        .wr_data (pht_wd)
    );

    bpb_btb #(
        .ENTRIES (BTB_SLOTS),
        .IW      (BTB_IW)
    ) u_btb (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (btb_rd_addr),
        .rd_data (btb_rd),
        .wr_en   (btb_we),
        .wr_addr (btb_wa),
        .wr_data (btb_wd)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= RST_MODE;
            penalty_reg   <= RST_PENALTY;
            hist_bits_reg <= RST_HIST;
            btb_en_reg    <= RST_BTB_EN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:    mode_reg      <= cfg_data[2:0];
                REG_PENALTY: penalty_reg   <= cfg_data;
                REG_HIST:    hist_bits_reg <= cfg_data[4:0];
                REG_BTB_EN:  btb_en_reg    <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clr_cnt_reg   <= '0;
            hist_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
                if (clr_cnt_reg == CLR_LAST)
                    clear_reg <= 1'b0;
            end
            if (s1_done && is_cond && (mode_reg == MODE_GSHARE))
                hist_reg <= hist_next;
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_done)
                s1_valid_reg <= 1'b0;
            if (s1_done)
                out_valid_reg <= 1'b1;
            else if (out_accept)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg  <= func;
            s1_pc_reg    <= pc;
            s1_tgt_reg   <= dest_pc;
            s1_taken_reg <= taken;
            s1_idx_reg   <= pht_rd_addr;
            s1_slot_reg  <= btb_rd_addr;
        end
        if (s1_done)
        begin
            bubbles_reg <= bub;
            mispred_reg <= (bub != 8'd0);
            pred_reg    <= is_cond && pred;
        end
    end

    assign out_valid    = out_valid_reg;
    assign bubbles      = bubbles_reg;
    assign mispredicted = mispred_reg;
    assign pred_taken   = pred_reg;
endmodule

>>> hdl/bpb_checker.sv
module bpb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] bubbles,
    input logic       mispredicted
);
    // flag agrees with the bubble count
    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mispredicted == (bubbles != 8'd0)))
        else $error("mispredicted flag disagrees with bubbles");

    // one request in flight: the cycle after an accept is stalled
    a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted back to back");

    // a new result only appears after the input has been stalled
    a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a request in flight");

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");
endmodule

bind branch_predictor_with_btb_top bpb_checker u_bpb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bubbles      (bubbles),
    .mispredicted (mispredicted)
);
